FILE: rtl/ldf_pkg.sv
// Shared types, constants and a helper function for the luma deblocking edge filter.
package ldf_pkg;

  // Default sample width and the fixed widths of the side-information fields.
  localparam int unsigned SAMPLE_BITS_DEF = 10;
  localparam int unsigned TC_W            = 10;
  localparam int unsigned THR_W           = 12;
  localparam int unsigned MASK_W          = 2;

  // Width of the signed arithmetic inside the filters. It covers the largest
  // intermediate value (the weighted weak-filter sum) for samples up to 10 bits.
  localparam int unsigned CALC_W = 16;

  // Number of samples on the input line and on the filtered result.
  localparam int unsigned NUM_IN  = 8;
  localparam int unsigned NUM_OUT = 6;

  // Positions of the samples in the input line.
  localparam int unsigned IDX_P3 = 0;
  localparam int unsigned IDX_P2 = 1;
  localparam int unsigned IDX_P1 = 2;
  localparam int unsigned IDX_P0 = 3;
  localparam int unsigned IDX_Q0 = 4;
  localparam int unsigned IDX_Q1 = 5;
  localparam int unsigned IDX_Q2 = 6;
  localparam int unsigned IDX_Q3 = 7;

  // Positions of the samples in the filtered result.
  localparam int unsigned OUT_P2 = 0;
  localparam int unsigned OUT_P1 = 1;
  localparam int unsigned OUT_P0 = 2;
  localparam int unsigned OUT_Q0 = 3;
  localparam int unsigned OUT_Q1 = 4;
  localparam int unsigned OUT_Q2 = 5;

  // Bits of the second-sample mask.
  localparam int unsigned MASK_P1 = 0;
  localparam int unsigned MASK_Q1 = 1;

  // Rounding offsets.
  localparam logic signed [CALC_W-1:0] RND1 = CALC_W'(1);
  localparam logic signed [CALC_W-1:0] RND2 = CALC_W'(2);
  localparam logic signed [CALC_W-1:0] RND4 = CALC_W'(4);
  localparam logic signed [CALC_W-1:0] RND8 = CALC_W'(8);

  typedef enum logic {
    OP_WEAK   = 1'b0,
    OP_STRONG = 1'b1
  } op_e;

  // Weak-filter side information carried along with a line.
  typedef struct packed {
    logic [THR_W-1:0]  thr_cut;
    logic [MASK_W-1:0] second_mask;
  } weak_ctrl_t;

  // Clamp x into the range lo..hi (lo is applied last, as in the standard).
  function automatic logic signed [CALC_W-1:0] clip3(
    input logic signed [CALC_W-1:0] lo,
    input logic signed [CALC_W-1:0] hi,
    input logic signed [CALC_W-1:0] x
  );
    logic signed [CALC_W-1:0] r;
    r = x;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

endpackage

FILE: rtl/ldf_strong.sv
// Strong luma filter: rounded 4- and 5-tap averages clipped around the old samples.
module ldf_strong
  import ldf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0] smp_i [NUM_IN],
  input  logic [TC_W-1:0]        tc_i,
  output logic [SAMPLE_BITS-1:0] res_o [NUM_OUT]
);

  always_comb begin
    logic signed [CALC_W-1:0] p3, p2, p1, p0, q0, q1, q2, q3, tc, tc2, tc3;
    logic signed [CALC_W-1:0] sp, sq, a_p2, a_p1, a_p0, a_q0, a_q1, a_q2;
    logic signed [CALC_W-1:0] r_p2, r_p1, r_p0, r_q0, r_q1, r_q2;
    p3  = $signed(CALC_W'(smp_i[IDX_P3]));
    p2  = $signed(CALC_W'(smp_i[IDX_P2]));
    p1  = $signed(CALC_W'(smp_i[IDX_P1]));
    p0  = $signed(CALC_W'(smp_i[IDX_P0]));
    q0  = $signed(CALC_W'(smp_i[IDX_Q0]));
    q1  = $signed(CALC_W'(smp_i[IDX_Q1]));
    q2  = $signed(CALC_W'(smp_i[IDX_Q2]));
    q3  = $signed(CALC_W'(smp_i[IDX_Q3]));
    tc  = $signed(CALC_W'(tc_i));
    tc2 = tc <<< 1;
    tc3 = tc2 + tc;

    sp = p2 + p1 + p0 + q0;
    sq = q2 + q1 + q0 + p0;

    a_p2 = (sp + ((p3 + p2) <<< 1) + RND4) >>> 3;
    a_p1 = (sp + RND2) >>> 2;
    a_p0 = ((sp <<< 1) + q1 - p2 + RND4) >>> 3;
    a_q0 = ((sq <<< 1) + p1 - q2 + RND4) >>> 3;
    a_q1 = (sq + RND2) >>> 2;
    a_q2 = (sq + ((q3 + q2) <<< 1) + RND4) >>> 3;

    // The clip windows all contain the old sample, so results stay in range.
    r_p2 = clip3(p2 - tc,  p2 + tc,  a_p2);
    r_p1 = clip3(p1 - tc2, p1 + tc2, a_p1);
    r_p0 = clip3(p0 - tc3, p0 + tc3, a_p0);
    r_q0 = clip3(q0 - tc3, q0 + tc3, a_q0);
    r_q1 = clip3(q1 - tc2, q1 + tc2, a_q1);
    r_q2 = clip3(q2 - tc,  q2 + tc,  a_q2);

    res_o[OUT_P2] = r_p2[SAMPLE_BITS-1:0];
    res_o[OUT_P1] = r_p1[SAMPLE_BITS-1:0];
    res_o[OUT_P0] = r_p0[SAMPLE_BITS-1:0];
    res_o[OUT_Q0] = r_q0[SAMPLE_BITS-1:0];
    res_o[OUT_Q1] = r_q1[SAMPLE_BITS-1:0];
    res_o[OUT_Q2] = r_q2[SAMPLE_BITS-1:0];
  end

endmodule

FILE: rtl/ldf_weak.sv
// Weak luma filter: thresholded delta correction of p0/q0 and optionally p1/q1.
module ldf_weak
  import ldf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0] smp_i [NUM_IN],
  input  logic [TC_W-1:0]        tc_i,
  input  weak_ctrl_t             ctrl_i,
  input  logic [SAMPLE_BITS-1:0] sample_max_i,
  output logic [SAMPLE_BITS-1:0] res_o [NUM_OUT]
);

  always_comb begin
    logic signed [CALC_W-1:0] p2, p1, p0, q0, q1, q2, tc, half, thr, smax;
    logic signed [CALC_W-1:0] d0, d1, delta, mag, dc, dp, dq;
    logic signed [CALC_W-1:0] r_p1, r_p0, r_q0, r_q1;
    p2   = $signed(CALC_W'(smp_i[IDX_P2]));
    p1   = $signed(CALC_W'(smp_i[IDX_P1]));
    p0   = $signed(CALC_W'(smp_i[IDX_P0]));
    q0   = $signed(CALC_W'(smp_i[IDX_Q0]));
    q1   = $signed(CALC_W'(smp_i[IDX_Q1]));
    q2   = $signed(CALC_W'(smp_i[IDX_Q2]));
    tc   = $signed(CALC_W'(tc_i));
    half = tc >>> 1;
    thr  = $signed(CALC_W'(ctrl_i.thr_cut));
    smax = $signed(CALC_W'(sample_max_i));

    // delta = (9*(q0-p0) - 3*(q1-p1) + 8) >> 4, floor division.
    d0    = q0 - p0;
    d1    = q1 - p1;
    delta = ((d0 <<< 3) + d0 - ((d1 <<< 1) + d1) + RND8) >>> 4;
    mag   = (delta < 0) ? -delta : delta;
    dc    = clip3(-tc, tc, delta);

    dp = (((p2 + p0 + RND1) >>> 1) - p1 + dc) >>> 1;
    dq = (((q2 + q0 + RND1) >>> 1) - q1 - dc) >>> 1;

    r_p0 = clip3('0, smax, p0 + dc);
    r_q0 = clip3('0, smax, q0 - dc);
    r_p1 = clip3('0, smax, p1 + clip3(-half, half, dp));
    r_q1 = clip3('0, smax, q1 + clip3(-half, half, dq));

    // Unfiltered samples pass through by default.
    res_o[OUT_P2] = smp_i[IDX_P2];
    res_o[OUT_P1] = smp_i[IDX_P1];
    res_o[OUT_P0] = smp_i[IDX_P0];
    res_o[OUT_Q0] = smp_i[IDX_Q0];
    res_o[OUT_Q1] = smp_i[IDX_Q1];
    res_o[OUT_Q2] = smp_i[IDX_Q2];
    if (mag < thr) begin
      res_o[OUT_P0] = r_p0[SAMPLE_BITS-1:0];
      res_o[OUT_Q0] = r_q0[SAMPLE_BITS-1:0];
      if (ctrl_i.second_mask[MASK_P1]) begin
        res_o[OUT_P1] = r_p1[SAMPLE_BITS-1:0];
      end
      if (ctrl_i.second_mask[MASK_Q1]) begin
        res_o[OUT_Q1] = r_q1[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

FILE: rtl/luma_deblocking_edge_filter.sv
// Top level of the luma deblocking edge filter: input stage, filters, result register.
//
// Usage: a request carries one line of eight samples across a block edge
// (p3..p0 | q0..q3) with tc, the weak-filter threshold, the weak/strong
// selector and the second-sample mask. It is taken at a rising clock edge at
// which start_i is high and busy_o is low. busy_o is held low: the block
// accepts a new line in every cycle.
// The six filtered samples p2..q2 appear on the result ports, done_o high
// for exactly one cycle, after the line has passed the input stage register
// and the result register. The receiver cannot stall the block; results
// must be consumed when flagged.
// Throughput is one line per cycle; the filter is a single combinational pass
// between the input stage register and the result register, and that pass
// (the weighted delta sum and its clips) sets the clock period.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes sample_max,
// the upper clip bound of weak-filter results. It is always ready and must
// only be written while no request is in flight.
// Reset (rst_ni low, asynchronous) empties the pipeline, drops done_o and
// sets sample_max to the largest value of a SAMPLE_BITS-wide sample.
module luma_deblocking_edge_filter
  import ldf_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [SAMPLE_BITS-1:0] cfg_sample_max_i,
  // Request
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   operation_i,
  input  logic [SAMPLE_BITS-1:0] p3_i,
  input  logic [SAMPLE_BITS-1:0] p2_i,
  input  logic [SAMPLE_BITS-1:0] p1_i,
  input  logic [SAMPLE_BITS-1:0] p0_i,
  input  logic [SAMPLE_BITS-1:0] q0_i,
  input  logic [SAMPLE_BITS-1:0] q1_i,
  input  logic [SAMPLE_BITS-1:0] q2_i,
  input  logic [SAMPLE_BITS-1:0] q3_i,
  input  logic [TC_W-1:0]        clip_tc_i,
  input  logic [THR_W-1:0]       thr_cut_i,
  input  logic [MASK_W-1:0]      second_mask_i,
  // Result
  output logic                   done_o,
  output logic [SAMPLE_BITS-1:0] p2_out_o,
  output logic [SAMPLE_BITS-1:0] p1_out_o,
  output logic [SAMPLE_BITS-1:0] p0_out_o,
  output logic [SAMPLE_BITS-1:0] q0_out_o,
  output logic [SAMPLE_BITS-1:0] q1_out_o,
  output logic [SAMPLE_BITS-1:0] q2_out_o
);

  logic                   req_accept;

  // Configuration register.
  logic [SAMPLE_BITS-1:0] sample_max_q;

  // Input stage register.
  logic                   stg_vld_q;
  op_e                    stg_op_q;
  logic [SAMPLE_BITS-1:0] stg_smp_q [NUM_IN];
  logic [TC_W-1:0]        stg_tc_q;
  weak_ctrl_t             stg_ctrl_q;

  // Filter outputs and result register.
  logic [SAMPLE_BITS-1:0] strong_res [NUM_OUT];
  logic [SAMPLE_BITS-1:0] weak_res   [NUM_OUT];
  logic [SAMPLE_BITS-1:0] res_d      [NUM_OUT];
  logic [SAMPLE_BITS-1:0] res_q      [NUM_OUT];
  logic                   done_q;

  // No internal back-pressure: every cycle can take a request and a write.
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign req_accept  = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_max_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sample_max_q <= cfg_sample_max_i;
    end
  end

  // Stage valid and result strobe are control state and get reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      stg_vld_q <= req_accept;
      done_q    <= stg_vld_q;
    end
  end

  // Payload registers load only when there is something to carry.
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      stg_op_q               <= op_e'(operation_i);
      stg_smp_q[IDX_P3]      <= p3_i;
      stg_smp_q[IDX_P2]      <= p2_i;
      stg_smp_q[IDX_P1]      <= p1_i;
      stg_smp_q[IDX_P0]      <= p0_i;
      stg_smp_q[IDX_Q0]      <= q0_i;
      stg_smp_q[IDX_Q1]      <= q1_i;
      stg_smp_q[IDX_Q2]      <= q2_i;
      stg_smp_q[IDX_Q3]      <= q3_i;
      stg_tc_q               <= clip_tc_i;
      stg_ctrl_q.thr_cut     <= thr_cut_i;
      stg_ctrl_q.second_mask <= second_mask_i;
    end
    if (stg_vld_q) begin
      res_q <= res_d;
    end
  end

  ldf_strong #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_strong (
    .smp_i (stg_smp_q),
    .tc_i  (stg_tc_q),
    .res_o (strong_res)
  );

  ldf_weak #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_weak (
    .smp_i        (stg_smp_q),
    .tc_i         (stg_tc_q),
    .ctrl_i       (stg_ctrl_q),
    .sample_max_i (sample_max_q),
    .res_o        (weak_res)
  );

  // Both filters run on every line; the selector picks which result is kept.
  always_comb begin
    case (stg_op_q)
      OP_STRONG: res_d = strong_res;
      OP_WEAK:   res_d = weak_res;
      default:   res_d = weak_res;
    endcase
  end

  assign done_o   = done_q;
  assign p2_out_o = res_q[OUT_P2];
  assign p1_out_o = res_q[OUT_P1];
  assign p0_out_o = res_q[OUT_P0];
  assign q0_out_o = res_q[OUT_Q0];
  assign q1_out_o = res_q[OUT_Q1];
  assign q2_out_o = res_q[OUT_Q2];

  // Every taken request yields a result after the input stage and result registers.
  a_req_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> ##1 done_o)
    else $error("request did not produce a result two cycles later");

  // A result is only flagged when the input stage held a line.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(stg_vld_q))
    else $error("result flagged without a line in the input stage");

  // The weak filter never touches the outer samples p2 and q2.
  a_weak_keeps_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_vld_q && stg_op_q == OP_WEAK) |=>
      (p2_out_o == $past(stg_smp_q[IDX_P2]) && q2_out_o == $past(stg_smp_q[IDX_Q2])))
    else $error("weak filter changed p2 or q2");

endmodule

FILE: test/luma_deblocking_edge_filter_tb.sv
// Self-checking testbench for the luma deblocking edge filter: directed table, then random lines.
module luma_deblocking_edge_filter_tb
  import ldf_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default sample width.
  localparam int unsigned SW = SAMPLE_BITS_DEF;

  // A taken request reaches its flagged result through the input stage register
  // and the result register, so DRAIN_CYCLES of quiet leave the pipeline empty.
  localparam int DRAIN_CYCLES = 4;

  // The watchdog gives up after this many cycles in which nothing moved.
  localparam int QUIET_LIMIT = 1000;

  // Random part: one phase per sample_max setting.
  localparam int PHASES          = 6;
  localparam int LINES_PER_PHASE = 175;
  localparam int STEADY_PHASE    = 2;

  localparam bit TYPED = 1'b1;
  localparam bit PRED  = 1'b0;

  // One edge line as it goes into the filter.
  typedef struct packed {
    op_e               op;
    logic [SW-1:0]     p3;
    logic [SW-1:0]     p2;
    logic [SW-1:0]     p1;
    logic [SW-1:0]     p0;
    logic [SW-1:0]     q0;
    logic [SW-1:0]     q1;
    logic [SW-1:0]     q2;
    logic [SW-1:0]     q3;
    logic [TC_W-1:0]   tc;
    logic [THR_W-1:0]  thr;
    logic [MASK_W-1:0] mask;
  } line_req_t;

  // The six filtered samples, indexed by the OUT_* positions of the package.
  typedef logic [0:NUM_OUT-1][SW-1:0] line_res_t;

  // A row of the directed table. Rows marked TYPED carry their result written
  // out by hand; the others are checked against the filter model below.
  typedef struct packed {
    logic [SW-1:0] smax;
    line_req_t     req;
    logic          typed;
    line_res_t     res;
  } dir_row_t;

  localparam int DIR_ROWS = 22;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [SW-1:0]       cfg_sample_max_i = '0;
  logic                start_i          = 1'b0;
  logic                busy_o;
  logic                operation_i      = 1'b0;
  logic [SW-1:0]       p3_i             = '0;
  logic [SW-1:0]       p2_i             = '0;
  logic [SW-1:0]       p1_i             = '0;
  logic [SW-1:0]       p0_i             = '0;
  logic [SW-1:0]       q0_i             = '0;
  logic [SW-1:0]       q1_i             = '0;
  logic [SW-1:0]       q2_i             = '0;
  logic [SW-1:0]       q3_i             = '0;
  logic [TC_W-1:0]     clip_tc_i        = '0;
  logic [THR_W-1:0]    thr_cut_i        = '0;
  logic [MASK_W-1:0]   second_mask_i    = '0;
  logic                done_o;
  logic [SW-1:0]       p2_out_o;
  logic [SW-1:0]       p1_out_o;
  logic [SW-1:0]       p0_out_o;
  logic [SW-1:0]       q0_out_o;
  logic [SW-1:0]       q1_out_o;
  logic [SW-1:0]       q2_out_o;

  // Filtered lines still owed by the block, oldest first.
  line_res_t     owed_lines [$];
  // sample_max as the block should hold it; it follows each accepted write.
  logic [SW-1:0] smax_model = SW'(1023);
  int            mismatches = 0;
  int            quiet_cycles = 0;
  // Handshake flags, set at the rising edge and read by the driver at the
  // following falling edge.
  logic          line_taken = 1'b0;
  logic          cfg_taken  = 1'b0;
  // A directed row with a hand-written result hands it to the monitor here.
  bit            row_typed = 1'b0;
  line_res_t     row_res   = '0;

  string res_name [NUM_OUT] = '{"p2_out", "p1_out", "p0_out", "q0_out", "q1_out", "q2_out"};

  // Directed lines. They cover both filters at the sample extremes, the
  // threshold on either side of the weak-filter delta, each second-sample
  // mask, tc of zero, one and its maximum, both signs of the delta, and weak
  // lines whose samples lie above a lowered sample_max (including zero).
  dir_row_t dir_tab [DIR_ROWS] = '{
    // Strong filter on a flat black line: nothing can move.
    '{1023, '{OP_STRONG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, TYPED,
      '{0, 0, 0, 0, 0, 0}},
    // Strong filter on a flat white line with every control at its maximum.
    '{1023, '{OP_STRONG, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 4095, 3},
      TYPED, '{1023, 1023, 1023, 1023, 1023, 1023}},
    // Strong filter with tc of zero clips every sample back to its input.
    '{1023, '{OP_STRONG, 100, 200, 300, 400, 600, 700, 800, 900, 0, 0, 0}, TYPED,
      '{200, 300, 400, 600, 700, 800}},
    // Weak filter with a threshold of zero never applies.
    '{1023, '{OP_WEAK, 0, 0, 0, 0, 1023, 1023, 1023, 1023, 1023, 0, 3}, TYPED,
      '{0, 0, 0, 1023, 1023, 1023}},
    // Weak filter with tc of zero leaves every sample where it was.
    '{1023, '{OP_WEAK, 10, 20, 30, 40, 50, 60, 70, 80, 0, 4095, 3}, TYPED,
      '{20, 30, 40, 50, 60, 70}},
    // The delta here is exactly nine: a threshold of nine blocks the filter,
    // a threshold of ten lets it through.
    '{1023, '{OP_WEAK, 0, 0, 0, 0, 16, 0, 0, 0, 100, 9, 3}, TYPED,
      '{0, 0, 0, 16, 0, 0}},
    '{1023, '{OP_WEAK, 0, 0, 0, 0, 16, 0, 0, 0, 100, 10, 3}, PRED, '0},
    // Full-scale steps in both directions.
    '{1023, '{OP_WEAK, 0, 0, 0, 0, 1023, 1023, 1023, 1023, 1023, 4095, 3}, PRED, '0},
    '{1023, '{OP_WEAK, 1023, 1023, 1023, 1023, 0, 0, 0, 0, 1023, 4095, 3}, PRED, '0},
    // The same moderate step with the second-sample mask at 0, 1 and 2.
    '{1023, '{OP_WEAK, 100, 100, 100, 100, 300, 300, 300, 300, 200, 4095, 0}, PRED, '0},
    '{1023, '{OP_WEAK, 100, 100, 100, 100, 300, 300, 300, 300, 200, 4095, 1}, PRED, '0},
    '{1023, '{OP_WEAK, 100, 100, 100, 100, 300, 300, 300, 300, 200, 4095, 2}, PRED, '0},
    // Weak filter with tc of one: the second-sample correction is clipped to zero.
    '{1023, '{OP_WEAK, 500, 500, 500, 500, 540, 540, 540, 540, 1, 4095, 3}, PRED, '0},
    '{1023, '{OP_STRONG, 0, 0, 0, 0, 1023, 1023, 1023, 1023, 1023, 0, 0}, PRED, '0},
    '{1023, '{OP_STRONG, 1023, 1023, 1023, 1023, 0, 0, 0, 0, 1, 4095, 3}, PRED, '0},
    // Alternating extremes through both filters.
    '{1023, '{OP_STRONG, 1023, 0, 1023, 0, 1023, 0, 1023, 0, 512, 4095, 3}, PRED, '0},
    '{1023, '{OP_WEAK, 0, 1023, 0, 1023, 0, 1023, 0, 1023, 1023, 4095, 3}, PRED, '0},
    // A negative delta below the threshold, and an odd tc.
    '{1023, '{OP_WEAK, 300, 300, 300, 320, 300, 300, 300, 300, 5, 50, 3}, PRED, '0},
    '{1023, '{OP_WEAK, 200, 200, 200, 200, 230, 230, 230, 230, 7, 4095, 3}, PRED, '0},
    // Samples above an 8-bit sample_max: weak results are clipped to it,
    // strong results ignore it.
    '{255, '{OP_WEAK, 0, 0, 0, 0, 1023, 1023, 1023, 1023, 1023, 4095, 3}, PRED, '0},
    '{255, '{OP_STRONG, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 4095, 3},
      TYPED, '{1023, 1023, 1023, 1023, 1023, 1023}},
    // A sample_max of zero pulls every weak correction down to zero.
    '{0, '{OP_WEAK, 40, 50, 60, 70, 90, 100, 110, 120, 30, 4095, 3}, PRED, '0}
  };

  luma_deblocking_edge_filter u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_sample_max_i (cfg_sample_max_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .p3_i             (p3_i),
    .p2_i             (p2_i),
    .p1_i             (p1_i),
    .p0_i             (p0_i),
    .q0_i             (q0_i),
    .q1_i             (q1_i),
    .q2_i             (q2_i),
    .q3_i             (q3_i),
    .clip_tc_i        (clip_tc_i),
    .thr_cut_i        (thr_cut_i),
    .second_mask_i    (second_mask_i),
    .done_o           (done_o),
    .p2_out_o         (p2_out_o),
    .p1_out_o         (p1_out_o),
    .p0_out_o         (p0_out_o),
    .q0_out_o         (q0_out_o),
    .q1_out_o         (q1_out_o),
    .q2_out_o         (q2_out_o)
  );

  // 2 ns clock, low for the first half period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int clamp_int(int lo, int hi, int x);
    if (x > hi) x = hi;
    if (x < lo) x = lo;
    return x;
  endfunction

  // Filter model: what the block must return for one line under a given
  // sample_max. All arithmetic is done in plain 32-bit integers, where the
  // block's intermediate sums cannot overflow, and arithmetic right shifts
  // give the floor division that the filter definition calls for.
  function automatic line_res_t filter_line(line_req_t r, logic [SW-1:0] smax);
    int p3, p2, p1, p0, q0, q1, q2, q3;
    int tc, half, dlt, mag, sp, sq, dp, dq, top;
    line_res_t o;
    p3  = int'(r.p3);
    p2  = int'(r.p2);
    p1  = int'(r.p1);
    p0  = int'(r.p0);
    q0  = int'(r.q0);
    q1  = int'(r.q1);
    q2  = int'(r.q2);
    q3  = int'(r.q3);
    tc  = int'(r.tc);
    top = int'(smax);
    o[OUT_P2] = r.p2;
    o[OUT_P1] = r.p1;
    o[OUT_P0] = r.p0;
    o[OUT_Q0] = r.q0;
    o[OUT_Q1] = r.q1;
    o[OUT_Q2] = r.q2;
    if (r.op == OP_STRONG) begin
      // Rounded averages, each held within a multiple of tc of the old value.
      sp = p2 + p1 + p0 + q0;
      sq = q2 + q1 + q0 + p0;
      o[OUT_P2] = SW'(clamp_int(p2 - tc, p2 + tc, (sp + 2 * (p3 + p2) + 4) >>> 3));
      o[OUT_P1] = SW'(clamp_int(p1 - 2 * tc, p1 + 2 * tc, (sp + 2) >>> 2));
      o[OUT_P0] = SW'(clamp_int(p0 - 3 * tc, p0 + 3 * tc, (2 * sp + q1 - p2 + 4) >>> 3));
      o[OUT_Q0] = SW'(clamp_int(q0 - 3 * tc, q0 + 3 * tc, (2 * sq + p1 - q2 + 4) >>> 3));
      o[OUT_Q1] = SW'(clamp_int(q1 - 2 * tc, q1 + 2 * tc, (sq + 2) >>> 2));
      o[OUT_Q2] = SW'(clamp_int(q2 - tc, q2 + tc, (sq + 2 * (q3 + q2) + 4) >>> 3));
    end else begin
      dlt = (9 * (q0 - p0) - 3 * (q1 - p1) + 8) >>> 4;
      mag = (dlt < 0) ? -dlt : dlt;
      // A large delta means a real edge in the picture: leave it alone.
      if (mag < int'(r.thr)) begin
        half = tc >>> 1;
        dlt  = clamp_int(-tc, tc, dlt);
        o[OUT_P0] = SW'(clamp_int(0, top, p0 + dlt));
        o[OUT_Q0] = SW'(clamp_int(0, top, q0 - dlt));
        if (r.mask[MASK_P1]) begin
          dp = (((p2 + p0 + 1) >>> 1) - p1 + dlt) >>> 1;
          o[OUT_P1] = SW'(clamp_int(0, top, p1 + clamp_int(-half, half, dp)));
        end
        if (r.mask[MASK_Q1]) begin
          dq = (((q2 + q0 + 1) >>> 1) - q1 - dlt) >>> 1;
          o[OUT_Q1] = SW'(clamp_int(0, top, q1 + clamp_int(-half, half, dq)));
        end
      end
    end
    return o;
  endfunction

  // A sample near c, spread by up to s either way, kept in range.
  function automatic logic [SW-1:0] near(int c, int s);
    return SW'(clamp_int(0, 1023, c + int'($urandom_range(0, 2 * s)) - s));
  endfunction

  // Random line. Most lines are smooth on each side with a modest step at the
  // edge and small tc and threshold, as real blocking artifacts look; those
  // reach the weak-filter corrections and their clips. The rest are noise.
  function automatic line_req_t random_line();
    line_req_t r;
    int        base;
    int        step;
    r.op   = op_e'($urandom_range(0, 1));
    r.mask = MASK_W'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 65) begin
      base = int'($urandom_range(0, 1023));
      step = int'($urandom_range(0, 80)) - 40;
      r.p3 = near(base, 6);
      r.p2 = near(base, 6);
      r.p1 = near(base, 6);
      r.p0 = near(base, 6);
      r.q0 = near(base + step, 6);
      r.q1 = near(base + step, 6);
      r.q2 = near(base + step, 6);
      r.q3 = near(base + step, 6);
      r.tc  = ($urandom_range(0, 3) == 0) ? TC_W'($urandom_range(0, 1023))
                                          : TC_W'($urandom_range(0, 40));
      r.thr = ($urandom_range(0, 3) == 0) ? THR_W'($urandom_range(0, 4095))
                                          : THR_W'($urandom_range(0, 60));
    end else begin
      r.p3  = SW'($urandom_range(0, 1023));
      r.p2  = SW'($urandom_range(0, 1023));
      r.p1  = SW'($urandom_range(0, 1023));
      r.p0  = SW'($urandom_range(0, 1023));
      r.q0  = SW'($urandom_range(0, 1023));
      r.q1  = SW'($urandom_range(0, 1023));
      r.q2  = SW'($urandom_range(0, 1023));
      r.q3  = SW'($urandom_range(0, 1023));
      r.tc  = TC_W'($urandom_range(0, 1023));
      r.thr = THR_W'($urandom_range(0, 4095));
    end
    return r;
  endfunction

  task automatic drive_fields(line_req_t r);
    operation_i   <= r.op;
    p3_i          <= r.p3;
    p2_i          <= r.p2;
    p1_i          <= r.p1;
    p0_i          <= r.p0;
    q0_i          <= r.q0;
    q1_i          <= r.q1;
    q2_i          <= r.q2;
    q3_i          <= r.q3;
    clip_tc_i     <= r.tc;
    thr_cut_i     <= r.thr;
    second_mask_i <= r.mask;
  endtask

  // Present one request at a falling edge and hold it until it is taken.
  // start_i stays high afterwards; the caller lowers it only when it idles,
  // so start_i is never lowered and raised again within one time step.
  task automatic send_line(line_req_t r);
    drive_fields(r);
    start_i <= 1'b1;
    do @(negedge clk_i); while (!line_taken);
  endtask

  // An idle cycle on the request side, with junk on the payload.
  task automatic idle_cycle();
    start_i <= 1'b0;
    drive_fields(random_line());
    @(negedge clk_i);
  endtask

  // sample_max may only change while nothing is in flight: wait until every
  // owed line has come back, let the pipeline run dry, then write.
  task automatic load_sample_max(logic [SW-1:0] v);
    start_i <= 1'b0;
    while (owed_lines.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_sample_max_i <= v;
    cfg_valid_i      <= 1'b1;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  // Monitor: everything is sampled at the rising edge, where the block's
  // outputs and the driver's inputs still hold the values of the closing cycle.
  always @(posedge clk_i) begin
    line_req_t req;
    line_res_t got;
    line_res_t want;
    bit        moved;
    bit        took_line;
    bit        took_cfg;
    moved     = 1'b0;
    took_line = 1'b0;
    took_cfg  = 1'b0;

    // Results cannot be held off, so every flagged one is checked right here.
    if (done_o === 1'b1) begin
      moved = 1'b1;
      got[OUT_P2] = p2_out_o;
      got[OUT_P1] = p1_out_o;
      got[OUT_P0] = p0_out_o;
      got[OUT_Q0] = q0_out_o;
      got[OUT_Q1] = q1_out_o;
      got[OUT_Q2] = q2_out_o;
      if (owed_lines.size() == 0) begin
        $display("%0t: result with no request waiting: %0d %0d %0d %0d %0d %0d", $time,
                 got[OUT_P2], got[OUT_P1], got[OUT_P0], got[OUT_Q0], got[OUT_Q1],
                 got[OUT_Q2]);
        mismatches++;
      end else begin
        want = owed_lines.pop_front();
        for (int k = 0; k < NUM_OUT; k++) begin
          if (got[k] !== want[k]) begin
            $display("%0t: %s expected %0d, got %0d", $time, res_name[k], want[k], got[k]);
            mismatches++;
          end
        end
      end
    end

    // A request taken now: work out what it must produce under the current
    // sample_max, or use the hand-written result of a typed table row.
    if (start_i === 1'b1 && busy_o === 1'b0) begin
      moved       = 1'b1;
      req.op      = op_e'(operation_i);
      req.p3      = p3_i;
      req.p2      = p2_i;
      req.p1      = p1_i;
      req.p0      = p0_i;
      req.q0      = q0_i;
      req.q1      = q1_i;
      req.q2      = q2_i;
      req.q3      = q3_i;
      req.tc      = clip_tc_i;
      req.thr     = thr_cut_i;
      req.mask    = second_mask_i;
      owed_lines.push_back(row_typed ? row_res : filter_line(req, smax_model));
      took_line   = 1'b1;
    end
    line_taken <= took_line;

    if (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1) begin
      moved      = 1'b1;
      smax_model = cfg_sample_max_i;
      took_cfg   = 1'b1;
    end
    cfg_taken <= took_cfg;

    // Watchdog: a stuck handshake or a lost result shows up as a long quiet.
    if (moved) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no activity for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    logic [SW-1:0] smax_plan [PHASES];
    logic [SW-1:0] setting;
    smax_plan = '{1023, 0, 255, 1, 511, 700};

    // Reset is held from time zero and released at a falling edge.
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table, back to back. A row asking for another sample_max first
    // drains the block and rewrites the register.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].smax != smax_model) load_sample_max(dir_tab[i].smax);
      row_typed = dir_tab[i].typed;
      row_res   = dir_tab[i].res;
      send_line(dir_tab[i].req);
    end
    row_typed = 1'b0;

    // Random phases, each under its own sample_max: full scale, zero, 8 bit,
    // one, a middle value and a random one. Samples above a lowered
    // sample_max come up by themselves. One phase runs without gaps so the
    // block sees a long unbroken stream; elsewhere the request side may idle
    // before each line, drawing again after each idle, with a chance of 18 in a hundred.
    for (int ph = 0; ph < PHASES; ph++) begin
      setting = (ph == PHASES - 1) ? SW'($urandom_range(2, 1022)) : smax_plan[ph];
      load_sample_max(setting);
      for (int n = 0; n < LINES_PER_PHASE; n++) begin
        if (ph != STEADY_PHASE) begin
          while ($urandom_range(0, 99) < 18) idle_cycle();
        end
        send_line(random_line());
      end
    end

    // Let every owed line come back, then watch a little longer for strays.
    start_i <= 1'b0;
    while (owed_lines.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES + 2) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
